// ===== sv/assert_macros.svh =====
// Assertion macros shared by the redirect block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/tdr_pkg.sv =====
// Types, codes and checksum helper for the destination redirect block.
package tdr_pkg;

   localparam int IDX_W = 12;
   localparam int KEY_W = 48;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [KEY_W-1:0] key_type;

   localparam logic [1:0] KIND_PACKET = 2'd0;
   localparam logic [1:0] KIND_INSERT = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;

   localparam logic [2:0] ACT_PASS     = 3'd0;
   localparam logic [2:0] ACT_NO_MATCH = 3'd1;
   localparam logic [2:0] ACT_REDIRECT = 3'd2;
   localparam logic [2:0] ACT_TABLE_OK = 3'd3;
   localparam logic [2:0] ACT_FULL     = 3'd4;
   localparam logic [2:0] ACT_ABSENT   = 3'd5;

   localparam logic [31:0] LOOPBACK_ADDR  = 32'h7f00_0001;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [16:0] ETH_HDR_BYTES  = 17'd14;
   localparam logic [16:0] MIN_IP_FRAME   = 17'd34;
   localparam logic [16:0] TCP_HDR_BYTES  = 17'd20;

   // Search token walking the cell row.
   typedef struct packed {
      logic    valid;
      key_type key;
      logic    hit;
      idx_type hit_idx;
      logic [15:0] hit_proxy;
      logic    free;
      idx_type free_idx;
   } token_type;

   // Table write broadcast to every cell.
   typedef struct packed {
      logic    en;
      logic    set;
      idx_type idx;
      key_type key;
      logic [15:0] proxy;
   } write_type;

   // RFC 1624 eq. 3 for one 16-bit word.
   function automatic logic [15:0] csum_word(input logic [15:0] sum,
                                             input logic [15:0] oldw,
                                             input logic [15:0] neww);
      logic [17:0] s;
      logic [16:0] f;
      s = {2'b00, ~sum} + {2'b00, ~oldw} + {2'b00, neww};
      f = {1'b0, s[15:0]} + {15'd0, s[17:16]};
      f = {1'b0, f[15:0]} + {16'd0, f[16]};
      return ~f[15:0];
   endfunction

endpackage

// ===== sv/tcp_destination_redirect_top.sv =====
// Top level: TCP destination redirect with a linear cell-row lookup table.
// Flow: the search token walks the cell row one entry per cycle, then the finish
//   state decides and writes back, and rsp_valid is registered from that state.
// One request at a time: busy is high from the accepting edge until the strobe and
//   low again during the strobe cycle, so the next request lands at its end.
// Reset (synchronous): clears all entry valid bits, both counters and control;
//   no clearing pass is needed. The receiver cannot stall the strobe.
`include "assert_macros.svh"

module tcp_destination_redirect_top #(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_frame_len,
   input  logic [15:0] req_ether_type,
   input  logic [7:0]  req_ip_proto,
   input  logic [3:0]  req_ip_hdr_words,
   input  logic [31:0] req_dest_addr,
   input  logic [15:0] req_dest_port,
   input  logic [15:0] req_ip_sum,
   input  logic [15:0] req_tcp_sum,
   input  logic [15:0] req_proxy_port_in,
   output logic        rsp_valid,
   output logic [2:0]  rsp_action,
   output logic [31:0] rsp_new_dest_addr,
   output logic [15:0] rsp_new_dest_port,
   output logic [15:0] rsp_new_ip_sum,
   output logic [15:0] rsp_new_tcp_sum,
   output logic [63:0] rsp_redirect_total,
   output logic [63:0] rsp_miss_total
);
   import tdr_pkg::*;

   // Controller states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       accept;

   // Captured request
   logic [1:0]  kind_ff;
   logic [15:0] flen_ff, etype_ff, port_ff, isum_ff, tsum_ff, pin_ff;
   logic [7:0]  proto_ff;
   logic [3:0]  ihl_ff;
   logic [31:0] addr_ff;

   // Address part of the checksum patch: high word registered, low word combinational
   logic [15:0] ip_a_ff, tcp_a_ff;
   logic [15:0] ip_b, tcp_b, tcp_c;

   token_type head_tok;
   token_type chain_tok [TABLE_ENTRIES+1];
   token_type lookup_ff;
   write_type wr;

   logic [63:0] redirect_count_ff, redirect_count_in;
   logic [63:0] miss_count_ff, miss_count_in;

   logic        rsp_valid_ff;
   logic [2:0]  action_ff, action_in;
   logic [31:0] naddr_ff, naddr_in;
   logic [15:0] nport_ff, nport_in, nisum_ff, nisum_in, ntsum_ff, ntsum_in;

   logic        parsed;
   logic [16:0] tcp_end;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Inject the search token straight from the request ports.
   always_comb begin
      head_tok       = '0;
      head_tok.valid = accept;
      head_tok.key   = {req_dest_addr, req_dest_port};
   end

   assign chain_tok[0] = head_tok;

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      tdr_cell #(.CELL_INDEX(g)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (chain_tok[g]),
         .wr      (wr),
         .tok_out (chain_tok[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_kind;
         flen_ff  <= req_frame_len;
         etype_ff <= req_ether_type;
         proto_ff <= req_ip_proto;
         ihl_ff   <= req_ip_hdr_words;
         addr_ff  <= req_dest_addr;
         port_ff  <= req_dest_port;
         isum_ff  <= req_ip_sum;
         tsum_ff  <= req_tcp_sum;
         pin_ff   <= req_proxy_port_in;
      end
   end

   // High address word patched in the cycle after capture; settles before finish.
   always_ff @(posedge clock) begin
      ip_a_ff  <= csum_word(isum_ff, addr_ff[31:16], LOOPBACK_ADDR[31:16]);
      tcp_a_ff <= csum_word(tsum_ff, addr_ff[31:16], LOOPBACK_ADDR[31:16]);
   end

   assign ip_b  = csum_word(ip_a_ff, addr_ff[15:0], LOOPBACK_ADDR[15:0]);
   assign tcp_b = csum_word(tcp_a_ff, addr_ff[15:0], LOOPBACK_ADDR[15:0]);
   assign tcp_c = csum_word(tcp_b, port_ff, lookup_ff.hit_proxy);

   // Header checks: Ethernet + IPv4 minimum, IPv4 ethertype, TCP protocol, then TCP header past the IHL.
   assign tcp_end = ETH_HDR_BYTES + {11'd0, ihl_ff, 2'b00} + TCP_HDR_BYTES;
   assign parsed  = ({1'b0, flen_ff} >= MIN_IP_FRAME) && (etype_ff == ETHERTYPE_IPV4)
                    && (proto_ff == PROTO_TCP) && (tcp_end <= {1'b0, flen_ff});

   always_ff @(posedge clock) begin
      if (state_ff == ST_SEARCH && chain_tok[TABLE_ENTRIES].valid) begin
         lookup_ff <= chain_tok[TABLE_ENTRIES];
      end
   end

   // Next-state logic; in the finish step also action, table write, counters and rewritten fields.
   always_comb begin
      state_in          = state_ff;
      action_in         = ACT_PASS;
      naddr_in          = addr_ff;
      nport_in          = port_ff;
      nisum_in          = isum_ff;
      ntsum_in          = tsum_ff;
      redirect_count_in = redirect_count_ff;
      miss_count_in     = miss_count_ff;
      wr                = '0;
      wr.key            = {addr_ff, port_ff};
      wr.proxy          = pin_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (chain_tok[TABLE_ENTRIES].valid) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
            case (kind_ff)
               KIND_PACKET: begin
                  if (parsed && lookup_ff.hit) begin
                     action_in         = ACT_REDIRECT;
                     naddr_in          = LOOPBACK_ADDR;
                     nport_in          = lookup_ff.hit_proxy;
                     nisum_in          = ip_b;
                     ntsum_in          = tcp_c;
                     redirect_count_in = redirect_count_ff + 64'd1;
                  end else if (parsed) begin
                     action_in     = ACT_NO_MATCH;
                     miss_count_in = miss_count_ff + 64'd1;
                  end
               end
               KIND_INSERT: begin
                  if (lookup_ff.hit || lookup_ff.free) begin
                     action_in = ACT_TABLE_OK;
                     wr.en     = 1'b1;
                     wr.set    = 1'b1;
                     wr.idx    = lookup_ff.hit ? lookup_ff.hit_idx : lookup_ff.free_idx;
                  end else begin
                     action_in = ACT_FULL;
                  end
               end
               KIND_REMOVE: begin
                  if (lookup_ff.hit) begin
                     action_in = ACT_TABLE_OK;
                     wr.en     = 1'b1;
                     wr.idx    = lookup_ff.hit_idx;
                  end else begin
                     action_in = ACT_ABSENT;
                  end
               end
               default: begin
                  action_in = ACT_PASS;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         rsp_valid_ff      <= 1'b0;
         redirect_count_ff <= '0;
         miss_count_ff     <= '0;
      end else begin
         state_ff          <= state_in;
         rsp_valid_ff      <= (state_ff == ST_FINISH);
         redirect_count_ff <= redirect_count_in;
         miss_count_ff     <= miss_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FINISH) begin
         action_ff <= action_in;
         naddr_ff  <= naddr_in;
         nport_ff  <= nport_in;
         nisum_ff  <= nisum_in;
         ntsum_ff  <= ntsum_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_action         = action_ff;
   assign rsp_new_dest_addr  = naddr_ff;
   assign rsp_new_dest_port  = nport_ff;
   assign rsp_new_ip_sum     = nisum_ff;
   assign rsp_new_tcp_sum    = ntsum_ff;
   assign rsp_redirect_total = redirect_count_ff;
   assign rsp_miss_total     = miss_count_ff;

   `ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid_ff, !rsp_valid_ff, "strobe held")
   `ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "not busy after accept")
   `ASSERT_IMPLIES(a_tail_in_search, clock, reset, chain_tok[TABLE_ENTRIES].valid,
                   state_ff == ST_SEARCH, "token left row outside search")
   `ASSERT_IMPLIES(a_write_in_finish, clock, reset, wr.en, state_ff == ST_FINISH,
                   "table write outside finish")

endmodule

// ===== sv/tdr_cell.sv =====
// One table entry of the lookup row; compares the passing token and forwards it.
module tdr_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  tdr_pkg::token_type tok_in,
   input  tdr_pkg::write_type wr,
   output tdr_pkg::token_type tok_out
);
   import tdr_pkg::*;

   key_type     key_ff;
   logic [15:0] proxy_ff;
   logic        valid_ff;
   token_type   tok_ff, tok_in_next;
   logic        wr_here;

   assign wr_here = wr.en && (wr.idx == idx_type'(CELL_INDEX));

   always_comb begin
      tok_in_next = tok_in;
      if (tok_in.valid && !tok_in.hit && valid_ff && key_ff == tok_in.key) begin
         tok_in_next.hit       = 1'b1;
         tok_in_next.hit_idx   = idx_type'(CELL_INDEX);
         tok_in_next.hit_proxy = proxy_ff;
      end
      if (tok_in.valid && !tok_in.free && !valid_ff) begin
         tok_in_next.free     = 1'b1;
         tok_in_next.free_idx = idx_type'(CELL_INDEX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_here) begin
         valid_ff <= wr.set;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_here && wr.set) begin
         key_ff   <= wr.key;
         proxy_ff <= wr.proxy;
      end
   end

   // Only the token's valid bit needs a reset; the payload follows it.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in_next.valid;
      end
      tok_ff.key       <= tok_in_next.key;
      tok_ff.hit       <= tok_in_next.hit;
      tok_ff.hit_idx   <= tok_in_next.hit_idx;
      tok_ff.hit_proxy <= tok_in_next.hit_proxy;
      tok_ff.free      <= tok_in_next.free;
      tok_ff.free_idx  <= tok_in_next.free_idx;
   end

   assign tok_out = tok_ff;

endmodule

// ===== test/tdr_checker.sv =====
// Response checker for the TCP destination redirect block: predicts each response and compares it.
module tdr_checker #(
   parameter int ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_frame_len,
   input  logic [15:0] req_ether_type,
   input  logic [7:0]  req_ip_proto,
   input  logic [3:0]  req_ip_hdr_words,
   input  logic [31:0] req_dest_addr,
   input  logic [15:0] req_dest_port,
   input  logic [15:0] req_ip_sum,
   input  logic [15:0] req_tcp_sum,
   input  logic [15:0] req_proxy_port_in,
   input  logic        rsp_valid,
   input  logic [2:0]  rsp_action,
   input  logic [31:0] rsp_new_dest_addr,
   input  logic [15:0] rsp_new_dest_port,
   input  logic [15:0] rsp_new_ip_sum,
   input  logic [15:0] rsp_new_tcp_sum,
   input  logic [63:0] rsp_redirect_total,
   input  logic [63:0] rsp_miss_total,
   output int          fail_count,
   output int          backlog
);
   timeunit 1ns;
   timeprecision 1ps;
   import tdr_pkg::*;

   localparam int IHL_BYTES = 4;

   typedef struct {
      logic [2:0]  action;
      logic [31:0] addr;
      logic [15:0] port;
      logic [15:0] ip_sum;
      logic [15:0] tcp_sum;
      logic [63:0] redirects;
      logic [63:0] misses;
   } rewrite_type;

   rewrite_type rewrite_q[$];
   logic [47:0] nat_key[ENTRIES];
   logic [15:0] nat_proxy[ENTRIES];
   logic        nat_valid[ENTRIES];
   logic [63:0] redirects;
   logic [63:0] misses;
   int          errs;

   // One's complement patch of a 16-bit sum for one changed word.
   function automatic logic [15:0] patch_sum(input logic [15:0] hc, input logic [15:0] w_old,
                                             input logic [15:0] w_new);
      logic [31:0] acc;
      acc = {16'd0, ~hc} + {16'd0, ~w_old} + {16'd0, w_new};
      acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
      acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
      return ~acc[15:0];
   endfunction

   function automatic bit header_ok(input logic [15:0] flen, input logic [15:0] etype,
                                    input logic [7:0] proto, input logic [3:0] ihl);
      int need;
      need = int'(ETH_HDR_BYTES) + IHL_BYTES * int'(ihl) + int'(TCP_HDR_BYTES);
      return int'(flen) >= int'(MIN_IP_FRAME) && etype == ETHERTYPE_IPV4 &&
             proto == PROTO_TCP && need <= int'(flen);
   endfunction

   function automatic int find_entry(input logic [47:0] key);
      for (int i = 0; i < ENTRIES; i++)
         if (nat_valid[i] && nat_key[i] == key) return i;
      return -1;
   endfunction

   function automatic int free_entry();
      for (int i = 0; i < ENTRIES; i++)
         if (!nat_valid[i]) return i;
      return -1;
   endfunction

   task automatic forecast_rewrite();
      logic [47:0] key;
      int          slot;
      rewrite_type e;
      key = {req_dest_addr, req_dest_port};
      e.action  = ACT_PASS;
      e.addr    = req_dest_addr;
      e.port    = req_dest_port;
      e.ip_sum  = req_ip_sum;
      e.tcp_sum = req_tcp_sum;
      case (req_kind)
         KIND_PACKET: begin
            if (header_ok(req_frame_len, req_ether_type, req_ip_proto, req_ip_hdr_words)) begin
               slot = find_entry(key);
               if (slot < 0) begin
                  misses = misses + 64'd1;
                  e.action = ACT_NO_MATCH;
               end else begin
                  // address words hit both sums, the port only the TCP one
                  e.ip_sum  = patch_sum(e.ip_sum, req_dest_addr[31:16], LOOPBACK_ADDR[31:16]);
                  e.ip_sum  = patch_sum(e.ip_sum, req_dest_addr[15:0], LOOPBACK_ADDR[15:0]);
                  e.tcp_sum = patch_sum(e.tcp_sum, req_dest_addr[31:16], LOOPBACK_ADDR[31:16]);
                  e.tcp_sum = patch_sum(e.tcp_sum, req_dest_addr[15:0], LOOPBACK_ADDR[15:0]);
                  e.tcp_sum = patch_sum(e.tcp_sum, req_dest_port, nat_proxy[slot]);
                  e.addr = LOOPBACK_ADDR;
                  e.port = nat_proxy[slot];
                  redirects = redirects + 64'd1;
                  e.action = ACT_REDIRECT;
               end
            end
         end
         KIND_INSERT: begin
            slot = find_entry(key);
            if (slot < 0) slot = free_entry();
            if (slot < 0) begin
               e.action = ACT_FULL;
            end else begin
               nat_key[slot]   = key;
               nat_proxy[slot] = req_proxy_port_in;
               nat_valid[slot] = 1'b1;
               e.action = ACT_TABLE_OK;
            end
         end
         KIND_REMOVE: begin
            slot = find_entry(key);
            if (slot < 0) begin
               e.action = ACT_ABSENT;
            end else begin
               nat_valid[slot] = 1'b0;
               e.action = ACT_TABLE_OK;
            end
         end
         default: ;
      endcase
      e.redirects = redirects;
      e.misses    = misses;
      rewrite_q.push_back(e);
   endtask

   task automatic check_field(input string name, input logic [63:0] exp, input logic [63:0] act);
      if (act !== exp) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
         errs++;
      end
   endtask

   always @(posedge clock) begin : watch
      rewrite_type e;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) nat_valid[i] = 1'b0;
         redirects = 64'd0;
         misses = 64'd0;
         rewrite_q.delete();
      end else begin
         if (start === 1'b1 && busy === 1'b0) forecast_rewrite();
         if (rsp_valid === 1'b1) begin
            if (rewrite_q.size() == 0) begin
               $error("rsp_valid: no request outstanding, rsp_action 0x%0h", rsp_action);
               errs++;
            end else begin
               e = rewrite_q.pop_front();
               check_field("rsp_action", 64'(e.action), 64'(rsp_action));
               check_field("rsp_new_dest_addr", 64'(e.addr), 64'(rsp_new_dest_addr));
               check_field("rsp_new_dest_port", 64'(e.port), 64'(rsp_new_dest_port));
               check_field("rsp_new_ip_sum", 64'(e.ip_sum), 64'(rsp_new_ip_sum));
               check_field("rsp_new_tcp_sum", 64'(e.tcp_sum), 64'(rsp_new_tcp_sum));
               check_field("rsp_redirect_total", e.redirects, rsp_redirect_total);
               check_field("rsp_miss_total", e.misses, rsp_miss_total);
            end
         end
      end
      fail_count <= errs;
      backlog <= rewrite_q.size();
   end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the TCP destination redirect block: stimulus, run limit and verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tdr_pkg::*;

   localparam int TABLE_ENTRIES = 256;
   // Kind code the block must treat as a plain pass-through.
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   // Distinct keys used to overflow the table.
   localparam int FILL_KEYS = TABLE_ENTRIES + 8;
   localparam int POOL_KEYS = 12;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_kind;
   logic [15:0] req_frame_len;
   logic [15:0] req_ether_type;
   logic [7:0]  req_ip_proto;
   logic [3:0]  req_ip_hdr_words;
   logic [31:0] req_dest_addr;
   logic [15:0] req_dest_port;
   logic [15:0] req_ip_sum;
   logic [15:0] req_tcp_sum;
   logic [15:0] req_proxy_port_in;
   logic        rsp_valid;
   logic [2:0]  rsp_action;
   logic [31:0] rsp_new_dest_addr;
   logic [15:0] rsp_new_dest_port;
   logic [15:0] rsp_new_ip_sum;
   logic [15:0] rsp_new_tcp_sum;
   logic [63:0] rsp_redirect_total;
   logic [63:0] rsp_miss_total;
   int          fail_count;
   int          backlog;

   // One request as driven onto the req_ ports.
   typedef struct {
      logic [1:0]  kind;
      logic [15:0] frame_len;
      logic [15:0] ether_type;
      logic [7:0]  ip_proto;
      logic [3:0]  ip_hdr_words;
      logic [31:0] dest_addr;
      logic [15:0] dest_port;
      logic [15:0] ip_sum;
      logic [15:0] tcp_sum;
      logic [15:0] proxy_port_in;
   } req_type;

   // Small set of keys that most requests reuse, so lookups actually hit.
   logic [31:0] pool_addr[POOL_KEYS];
   logic [15:0] pool_port[POOL_KEYS];

   tcp_destination_redirect_top #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_frame_len(req_frame_len), .req_ether_type(req_ether_type),
      .req_ip_proto(req_ip_proto), .req_ip_hdr_words(req_ip_hdr_words),
      .req_dest_addr(req_dest_addr), .req_dest_port(req_dest_port),
      .req_ip_sum(req_ip_sum), .req_tcp_sum(req_tcp_sum),
      .req_proxy_port_in(req_proxy_port_in),
      .rsp_valid(rsp_valid), .rsp_action(rsp_action),
      .rsp_new_dest_addr(rsp_new_dest_addr), .rsp_new_dest_port(rsp_new_dest_port),
      .rsp_new_ip_sum(rsp_new_ip_sum), .rsp_new_tcp_sum(rsp_new_tcp_sum),
      .rsp_redirect_total(rsp_redirect_total), .rsp_miss_total(rsp_miss_total)
   );

   tdr_checker #(.ENTRIES(TABLE_ENTRIES)) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_frame_len(req_frame_len), .req_ether_type(req_ether_type),
      .req_ip_proto(req_ip_proto), .req_ip_hdr_words(req_ip_hdr_words),
      .req_dest_addr(req_dest_addr), .req_dest_port(req_dest_port),
      .req_ip_sum(req_ip_sum), .req_tcp_sum(req_tcp_sum),
      .req_proxy_port_in(req_proxy_port_in),
      .rsp_valid(rsp_valid), .rsp_action(rsp_action),
      .rsp_new_dest_addr(rsp_new_dest_addr), .rsp_new_dest_port(rsp_new_dest_port),
      .rsp_new_ip_sum(rsp_new_ip_sum), .rsp_new_tcp_sum(rsp_new_tcp_sum),
      .rsp_redirect_total(rsp_redirect_total), .rsp_miss_total(rsp_miss_total),
      .fail_count(fail_count), .backlog(backlog)
   );

   // 4 ns clock: 2 ns high, 2 ns low.
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Run limit. The slowest legal run is roughly 700 requests, each busy for a
   // full walk of the cell row plus its idle gap and any wait for the block to
   // go idle; that stays well under this limit, which leaves a wide margin.
   initial begin
      #3_200_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Plain TCP/IPv4 header with the given length fields, key and sums.
   function automatic req_type tcp_hdr(input logic [15:0] flen, input logic [3:0] ihl,
                                       input logic [31:0] addr, input logic [15:0] port,
                                       input logic [15:0] isum, input logic [15:0] tsum);
      req_type r;
      r.kind          = KIND_PACKET;
      r.frame_len     = flen;
      r.ether_type    = ETHERTYPE_IPV4;
      r.ip_proto      = PROTO_TCP;
      r.ip_hdr_words  = ihl;
      r.dest_addr     = addr;
      r.dest_port     = port;
      r.ip_sum        = isum;
      r.tcp_sum       = tsum;
      r.proxy_port_in = 16'($urandom);
      return r;
   endfunction

   // Table insert or remove; header fields are junk the block must not care about.
   function automatic req_type tbl_op(input logic [1:0] kind, input logic [31:0] addr,
                                      input logic [15:0] port, input logic [15:0] proxy);
      req_type r;
      r.kind          = kind;
      r.frame_len     = 16'($urandom);
      r.ether_type    = 16'($urandom);
      r.ip_proto      = 8'($urandom);
      r.ip_hdr_words  = 4'($urandom);
      r.dest_addr     = addr;
      r.dest_port     = port;
      r.ip_sum        = 16'($urandom);
      r.tcp_sum       = 16'($urandom);
      r.proxy_port_in = proxy;
      return r;
   endfunction

   // Well-formed TCP frame with random header length and size; a tenth of
   // them are one byte short of the TCP header bound.
   function automatic req_type tcp_pkt(input logic [31:0] addr, input logic [15:0] port);
      logic [3:0] ihl;
      int         need;
      int         flen;
      ihl  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd5;
      need = 14 + 4 * int'(ihl) + 20;
      case ($urandom_range(0, 9))
         0:       flen = need - 1;
         1:       flen = need;
         2:       flen = $urandom_range(need, 65535);
         default: flen = need + $urandom_range(0, 1500);
      endcase
      return tcp_hdr(16'(flen), ihl, addr, port, 16'($urandom), 16'($urandom));
   endfunction

   // Anything at all, every kind code included.
   function automatic req_type noise();
      req_type r;
      r = tbl_op(2'($urandom), $urandom, 16'($urandom), 16'($urandom));
      return r;
   endfunction

   // Random mix: mostly valid traffic, largely on pool keys, some table churn, some garbage.
   function automatic req_type mixed();
      int p;
      p = $urandom_range(0, POOL_KEYS - 1);
      case ($urandom_range(0, 19))
         0, 1, 2:  return tbl_op(KIND_INSERT, pool_addr[p], pool_port[p], 16'($urandom));
         3, 4:     return tbl_op(KIND_REMOVE, pool_addr[p], pool_port[p], 16'($urandom));
         5, 6, 7:  return noise();
         8, 9:     return tcp_pkt($urandom, 16'($urandom));
         default:  return tcp_pkt(pool_addr[p], pool_port[p]);
      endcase
   endfunction

   // Idle burst length: a third of requests get an idle gap, the rest none.
   function automatic int idle_burst();
      return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 17) : 0;
   endfunction

   // Present one request and hold start until the block takes it.
   // Returns just after the accepting rising edge.
   task automatic send_request(input req_type r, input int gap);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         // half the bursts start only once the block has gone idle
         if ($urandom_range(0, 1) == 1) begin
            while (busy) @(posedge clock);
         end
         repeat (gap) @(negedge clock);
      end
      req_kind          <= r.kind;
      req_frame_len     <= r.frame_len;
      req_ether_type    <= r.ether_type;
      req_ip_proto      <= r.ip_proto;
      req_ip_hdr_words  <= r.ip_hdr_words;
      req_dest_addr     <= r.dest_addr;
      req_dest_port     <= r.dest_port;
      req_ip_sum        <= r.ip_sum;
      req_tcp_sum       <= r.tcp_sum;
      req_proxy_port_in <= r.proxy_port_in;
      start             <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Hold off the sender until every outstanding response has come back.
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      do @(posedge clock); while (backlog != 0);
   endtask

   initial begin : stimulus
      req_type r;
      int      j;
      localparam logic [31:0] ADDR_A = 32'hc0a8_0102;
      localparam logic [15:0] PORT_A = 16'd443;

      reset = 1'b1;
      start = 1'b0;
      req_kind = KIND_PACKET;
      req_frame_len = '0;
      req_ether_type = '0;
      req_ip_proto = '0;
      req_ip_hdr_words = '0;
      req_dest_addr = '0;
      req_dest_port = '0;
      req_ip_sum = '0;
      req_tcp_sum = '0;
      req_proxy_port_in = '0;

      // pool has the all-zero and all-ones keys plus random ones
      pool_addr[0] = 32'h0;
      pool_port[0] = 16'h0;
      pool_addr[1] = 32'hffff_ffff;
      pool_port[1] = 16'hffff;
      for (int i = 2; i < POOL_KEYS; i++) begin
         pool_addr[i] = $urandom;
         pool_port[i] = 16'($urandom);
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed: parse bounds, table ops, extremes ----
      send_request(tcp_hdr(16'd54, 4'd5, ADDR_A, PORT_A, 16'h0, 16'h0), 0);    // miss, empty table
      send_request(tcp_hdr(16'd53, 4'd5, ADDR_A, PORT_A, 16'h0, 16'h0), 0);    // TCP hdr short
      send_request(tcp_hdr(16'd34, 4'd0, ADDR_A, PORT_A, 16'h1, 16'h2), 0);    // IHL 0 still parses
      send_request(tcp_hdr(16'd33, 4'd0, ADDR_A, PORT_A, 16'h1, 16'h2), 0);    // IP hdr short
      r = tcp_hdr(16'd100, 4'd5, ADDR_A, PORT_A, 16'h0, 16'h0);
      r.ether_type = 16'h86dd;                                                  // not IPv4
      send_request(r, 0);
      r = tcp_hdr(16'd100, 4'd5, ADDR_A, PORT_A, 16'h0, 16'h0);
      r.ip_proto = 8'd17;                                                       // UDP
      send_request(r, 0);
      send_request(tbl_op(KIND_INSERT, ADDR_A, PORT_A, 16'hffff), 0);
      send_request(tbl_op(KIND_INSERT, ADDR_A, PORT_A, 16'd8080), 0);          // replace proxy
      send_request(tcp_hdr(16'd60, 4'd5, ADDR_A, PORT_A, 16'h0000, 16'hffff), 0);
      send_request(tcp_hdr(16'd1514, 4'd5, ADDR_A, PORT_A, 16'hffff, 16'h0000), 0);
      send_request(tbl_op(KIND_INSERT, 32'hffff_ffff, 16'hffff, 16'h0000), 0);
      send_request(tcp_hdr(16'hffff, 4'd15, 32'hffff_ffff, 16'hffff, 16'h1234, 16'habcd), 0);
      send_request(tcp_hdr(16'd93, 4'd15, 32'hffff_ffff, 16'hffff, 16'h0, 16'h0), 0); // 1 short
      send_request(tcp_hdr(16'd94, 4'd15, 32'hffff_ffff, 16'hffff, 16'h0, 16'h0), 0); // exact
      send_request(tbl_op(KIND_REMOVE, 32'h0a00_0001, 16'd80, 16'h0), 0);      // key absent
      send_request(tbl_op(KIND_REMOVE, ADDR_A, PORT_A, 16'h0), 0);
      send_request(tcp_hdr(16'd60, 4'd5, ADDR_A, PORT_A, 16'h5555, 16'haaaa), 0); // miss again
      r = noise();
      r.kind = KIND_UNUSED;
      send_request(r, 0);
      send_request(tcp_hdr(16'd0, 4'd0, 32'h0, 16'h0, 16'h0, 16'h0), 0);      // empty frame
      send_request(tbl_op(KIND_INSERT, 32'h0, 16'h0, 16'h1f90), 0);
      send_request(tcp_hdr(16'd34, 4'd0, 32'h0, 16'h0, 16'h0, 16'h0), 0);
      send_request(tbl_op(KIND_REMOVE, 32'h0, 16'h0, 16'h0), 0);
      send_request(tbl_op(KIND_REMOVE, 32'hffff_ffff, 16'hffff, 16'h0), 0);
      drain();

      // ---- random mix with idle bursts; every third stretch runs flat out ----
      for (int i = 0; i < 200; i++)
         send_request(mixed(), ((i / 40) % 3 == 2) ? 0 : idle_burst());
      drain();

      // ---- fill the table past capacity with distinct keys ----
      for (int i = 0; i < FILL_KEYS; i++)
         send_request(tbl_op(KIND_INSERT, {16'hc633, 16'(i)}, 16'(1000 + i), 16'($urandom)),
                      idle_burst());
      // traffic against a full table: hits, misses, refused inserts, churn
      for (int i = 0; i < 40; i++) begin
         j = $urandom_range(0, FILL_KEYS - 1);
         case ($urandom_range(0, 3))
            0, 1: send_request(tcp_pkt({16'hc633, 16'(j)}, 16'(1000 + j)), idle_burst());
            2:    send_request(tbl_op(KIND_INSERT, {16'hc634, 16'($urandom)}, 16'($urandom),
                                      16'($urandom)), idle_burst());
            default: begin
               send_request(tbl_op(KIND_REMOVE, {16'hc633, 16'(j)}, 16'(1000 + j),
                                   16'($urandom)), idle_burst());
               // reuse of the freed slot
               send_request(tbl_op(KIND_INSERT, {16'hc635, 16'(j)}, 16'(j), 16'($urandom)),
                            idle_burst());
            end
         endcase
      end

      // ---- last stretch: no idling, pool traffic plus freeing of fill keys ----
      for (int i = 0; i < 130; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            j = $urandom_range(0, FILL_KEYS - 1);
            send_request(tbl_op(KIND_REMOVE, {16'hc633, 16'(j)}, 16'(1000 + j),
                                16'($urandom)), 0);
         end else begin
            send_request(mixed(), 0);
         end
      end

      // ---- wind down: wait for the last responses, then the pipeline depth ----
      @(negedge clock);
      start <= 1'b0;
      do @(posedge clock); while (backlog != 0);
      repeat (TABLE_ENTRIES + 8) @(posedge clock);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
